### rtl/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, codes and score arithmetic for the global alignment scorer.
// ----------------------------------------------------------------------------
package gas_pkg;

   localparam int SCORE_W = 14;
   localparam int SUM_W   = 16;
   localparam int SYM_W   = 8;
   localparam int CSR_W   = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [SUM_W-1:0] SCORE_MIN = -16'sd8192;
   localparam logic signed [SUM_W-1:0] SCORE_MAX = 16'sd8191;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_GAIN       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH_PENALTY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_PENALTY      = 2'd2;

   localparam logic [3:0]       MATCH_GAIN_RST       = 4'd2;
   localparam logic signed [4:0] MISMATCH_PENALTY_RST = -5'sd1;
   localparam logic signed [4:0] GAP_PENALTY_RST      = -5'sd1;

   typedef enum logic [1:0] {
      FUNC_APPEND_FIRST  = 2'd0,
      FUNC_APPEND_SECOND = 2'd1,
      FUNC_RUN           = 2'd2
   } func_type;

   typedef struct packed {
      func_type         func;
      logic [SYM_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] align_score;
      logic                      overflowed;
   } rsp_type;

   // Saturate a widened sum back into the score range
   function automatic logic signed [SCORE_W-1:0] sat_score(logic signed [SUM_W-1:0] v);
      logic signed [SCORE_W-1:0] r;
      if (v < SCORE_MIN) begin
         r = SCORE_MIN[SCORE_W-1:0];
      end else if (v > SCORE_MAX) begin
         r = SCORE_MAX[SCORE_W-1:0];
      end else begin
         r = v[SCORE_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/gas_ram.sv
// ----------------------------------------------------------------------------
// gas_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Hold the last word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/global_alignment_scorer.sv
// ----------------------------------------------------------------------------
// global_alignment_scorer
// Needleman-Wunsch global alignment score with linear gap cost over two
// byte strings loaded one symbol per word.
// ----------------------------------------------------------------------------
// Append words are taken one per cycle and written straight into the symbol
// RAMs. A run word computes the score one matrix row at a time, keeping a
// single row in the score-row RAM: it writes the gap row, then for each
// symbol of the first string a row start followed by one cell per symbol of
// the second, read through the single read port of the score-row RAM, which
// delivers one cell a cycle. The input is held off during that sweep. The
// result sits in an output register, so further appends are taken while it
// waits; a second run waits for that register to drain before it finishes.
// ----------------------------------------------------------------------------
module global_alignment_scorer #(
   parameter int MAX_FIRST_LEN  = 256,
   parameter int MAX_SECOND_LEN = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gas_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gas_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [gas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gas_pkg::CSR_W-1:0]      csr_wdata
);

   import gas_pkg::*;

   localparam int LA_W = $clog2(MAX_FIRST_LEN + 1);
   localparam int LB_W = $clog2(MAX_SECOND_LEN + 1);
   localparam int A_AW = (MAX_FIRST_LEN > 1) ? $clog2(MAX_FIRST_LEN) : 1;
   localparam int B_AW = (MAX_SECOND_LEN > 1) ? $clog2(MAX_SECOND_LEN) : 1;
   localparam int ROW_DEPTH = MAX_SECOND_LEN + 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INIT   = 5'b00010,
      ST_ROWSEL = 5'b00100,
      ST_CELLS  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]          match_ff;
   logic signed [4:0]   mism_ff;
   logic signed [4:0]   gap_ff;

   logic [LA_W-1:0]     first_len_ff, first_len_in;
   logic [LB_W-1:0]     second_len_ff, second_len_in;
   logic                ovf_ff, ovf_in;
   logic [LA_W-1:0]     i_ff, i_in;
   logic [LB_W-1:0]     j_ff, j_in;
   logic signed [SCORE_W-1:0] left_ff, left_in;
   logic signed [SCORE_W-1:0] diag_ff, diag_in;
   logic signed [SCORE_W-1:0] col0_ff, col0_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                first_wr, second_wr;
   logic                first_rd, row_rd, row_wr;
   logic [LB_W-1:0]     row_rd_addr;
   logic [B_AW-1:0]     second_rd_addr;
   logic signed [SCORE_W-1:0] row_wr_data;
   logic [SYM_W-1:0]    first_q, second_q;
   logic [SCORE_W-1:0]  row_q;

   logic signed [SUM_W-1:0] pair_w, diag_sum, up_sum, left_sum, col0_sum, best;
   logic signed [SCORE_W-1:0] cell_val, left_gap, col0_gap;

   // ---------------------------------------------------------------- memories
   gas_ram #(.WIDTH(SYM_W), .DEPTH(MAX_FIRST_LEN), .AW(A_AW)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_wr),
      .wr_addr (first_len_ff[A_AW-1:0]),
      .wr_data (req_data.symbol),
      .rd_en   (first_rd),
      .rd_addr (i_ff[A_AW-1:0]),
      .rd_data (first_q)
   );

   gas_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SECOND_LEN), .AW(B_AW)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_wr),
      .wr_addr (second_len_ff[B_AW-1:0]),
      .wr_data (req_data.symbol),
      .rd_en   (row_rd),
      .rd_addr (second_rd_addr),
      .rd_data (second_q)
   );

   gas_ram #(.WIDTH(SCORE_W), .DEPTH(ROW_DEPTH), .AW(LB_W)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr),
      .wr_addr (j_ff),
      .wr_data (row_wr_data),
      .rd_en   (row_rd),
      .rd_addr (row_rd_addr),
      .rd_data (row_q)
   );

   // ---------------------------------------------------------------- datapath
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign first_wr  = req_fire && (req_data.func == FUNC_APPEND_FIRST)
                      && (first_len_ff < LA_W'(MAX_FIRST_LEN));
   assign second_wr = req_fire && (req_data.func == FUNC_APPEND_SECOND)
                      && (second_len_ff < LB_W'(MAX_SECOND_LEN));

   always_comb begin
      pair_w   = (first_q == second_q) ? SUM_W'($signed({1'b0, match_ff}))
                                       : SUM_W'(mism_ff);
      diag_sum = SUM_W'(diag_ff) + pair_w;
      up_sum   = SUM_W'($signed(row_q)) + SUM_W'(gap_ff);
      left_sum = SUM_W'(left_ff) + SUM_W'(gap_ff);
      col0_sum = SUM_W'(col0_ff) + SUM_W'(gap_ff);
      best     = diag_sum;
      if (up_sum > best) begin
         best = up_sum;
      end
      if (left_sum > best) begin
         best = left_sum;
      end
      cell_val = sat_score(best);
      left_gap = sat_score(left_sum);
      col0_gap = sat_score(col0_sum);
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in       = state_ff;
      first_len_in   = first_len_ff;
      second_len_in  = second_len_ff;
      ovf_in         = ovf_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      left_in        = left_ff;
      diag_in        = diag_ff;
      col0_in        = col0_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      first_rd       = 1'b0;
      row_rd         = 1'b0;
      row_wr         = 1'b0;
      row_wr_data    = cell_val;
      row_rd_addr    = j_ff + LB_W'(1);
      second_rd_addr = j_ff[B_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.func)
                  FUNC_APPEND_FIRST: begin
                     if (first_wr) begin
                        first_len_in = first_len_ff + LA_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  FUNC_APPEND_SECOND: begin
                     if (second_wr) begin
                        second_len_in = second_len_ff + LB_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  FUNC_RUN: begin
                     left_in = '0;
                     col0_in = '0;
                     i_in    = '0;
                     j_in    = LB_W'(1);
                     state_in = (second_len_ff == '0) ? ST_ROWSEL : ST_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            // Gap row: each cell is the previous one plus a gap
            row_wr      = 1'b1;
            row_wr_data = left_gap;
            left_in     = left_gap;
            if (j_ff == second_len_ff) begin
               state_in = ST_ROWSEL;
            end else begin
               j_in = j_ff + LB_W'(1);
            end
         end
         ST_ROWSEL: begin
            if (i_ff == first_len_ff) begin
               state_in = ST_FINISH;
            end else begin
               // Fetch the row symbol and the first cell's operands
               first_rd       = 1'b1;
               row_rd         = (second_len_ff != '0);
               row_rd_addr    = LB_W'(1);
               second_rd_addr = '0;
               diag_in        = col0_ff;
               col0_in        = col0_gap;
               left_in        = col0_gap;
               i_in           = i_ff + LA_W'(1);
               j_in           = LB_W'(1);
               state_in       = (second_len_ff == '0) ? ST_ROWSEL : ST_CELLS;
            end
         end
         ST_CELLS: begin
            row_wr  = 1'b1;
            left_in = cell_val;
            diag_in = $signed(row_q);
            if (j_ff == second_len_ff) begin
               state_in = ST_ROWSEL;
            end else begin
               // Read the next cell while this one is written back
               row_rd = 1'b1;
               j_in   = j_ff + LB_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.align_score = left_ff;
               rsp_data_in.overflowed  = ovf_ff;
               first_len_in            = '0;
               second_len_in           = '0;
               ovf_in                  = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         match_ff      <= MATCH_GAIN_RST;
         mism_ff       <= MISMATCH_PENALTY_RST;
         gap_ff        <= GAP_PENALTY_RST;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MATCH_GAIN:       match_ff <= csr_wdata[3:0];
               CSR_MISMATCH_PENALTY: mism_ff  <= $signed(csr_wdata);
               CSR_GAP_PENALTY:      gap_ff   <= $signed(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      col0_ff     <= col0_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/gas_checker.sv
// ----------------------------------------------------------------------------
// gas_checker
// Port-level checks for the global alignment scorer, bound to the top level.
// ----------------------------------------------------------------------------
module gas_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input gas_pkg::req_type              req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input gas_pkg::rsp_type              rsp_data
);

   import gas_pkg::*;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // A run holds off the input on the next cycle
   a_run_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == FUNC_RUN) |=> !req_ready)
      else $error("input taken right after a run word");

   // A new result only appears at the end of a sweep
   a_rsp_after_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a sweep");

   // Reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind global_alignment_scorer gas_checker u_gas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/alignment_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alignment_score_checker
// Passive monitor for the global alignment scorer: tracks the register port
// and both channels, keeps its own copy of the loaded strings, predicts the
// score of every run word and compares each result word with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module alignment_score_checker #(
   parameter int FIRST_CAP  = 256,
   parameter int SECOND_CAP = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  gas_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  gas_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [gas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gas_pkg::CSR_W-1:0]      csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count,
   output int                             scores_checked,
   output int                             overflow_seen
);
   import gas_pkg::*;

   logic [SYM_W-1:0]  first_syms  [0:FIRST_CAP-1];
   logic [SYM_W-1:0]  second_syms [0:SECOND_CAP-1];
   int                first_len  = 0;
   int                second_len = 0;
   bit                dropped    = 1'b0;
   logic [3:0]        match_gain       = MATCH_GAIN_RST;
   logic signed [4:0] mismatch_penalty = MISMATCH_PENALTY_RST;
   logic signed [4:0] gap_penalty      = GAP_PENALTY_RST;
   rsp_type           score_q [$];
   int                errs    = 0;
   int                checked = 0;
   int                flagged = 0;

   function automatic int clamp_cell(int v);
      if (v < -8192) begin
         return -8192;
      end
      if (v > 8191) begin
         return 8191;
      end
      return v;
   endfunction

   // One-row Needleman-Wunsch sweep over the strings loaded so far
   function automatic logic signed [SCORE_W-1:0] predict_score();
      int row [0:SECOND_CAP];
      int n, m, i, j, diag, up, pair, best, mg, mp, gp;
      n  = (first_len < FIRST_CAP) ? first_len : FIRST_CAP;
      m  = (second_len < SECOND_CAP) ? second_len : SECOND_CAP;
      mg = match_gain;
      mp = mismatch_penalty;
      gp = gap_penalty;
      row[0] = 0;
      for (j = 1; j <= m; j++) begin
         row[j] = clamp_cell(row[j-1] + gp);
      end
      for (i = 1; i <= n; i++) begin
         diag   = row[0];
         row[0] = clamp_cell(row[0] + gp);
         for (j = 1; j <= m; j++) begin
            up   = row[j];
            pair = (first_syms[i-1] == second_syms[j-1]) ? mg : mp;
            best = diag + pair;
            if (up + gp > best) begin
               best = up + gp;
            end
            if (row[j-1] + gp > best) begin
               best = row[j-1] + gp;
            end
            row[j] = clamp_cell(best);
            diag   = up;
         end
      end
      best = row[m];
      return best[SCORE_W-1:0];
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         first_len        = 0;
         second_len       = 0;
         dropped          = 1'b0;
         match_gain       = MATCH_GAIN_RST;
         mismatch_penalty = MISMATCH_PENALTY_RST;
         gap_penalty      = GAP_PENALTY_RST;
         score_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (score_q.size() == 0) begin
               $display("%0t: unexpected result word: score %0d, overflowed %0b",
                        $time, $signed(got.align_score), got.overflowed);
               errs++;
            end else begin
               want = score_q.pop_front();
               checked++;
               if (want.overflowed) begin
                  flagged++;
               end
               if (got.align_score !== want.align_score) begin
                  $display("%0t: align_score mismatch: expected %0d, actual %0d",
                           $time, $signed(want.align_score), $signed(got.align_score));
                  errs++;
               end
               if (got.overflowed !== want.overflowed) begin
                  $display("%0t: overflowed mismatch: expected %0b, actual %0b",
                           $time, want.overflowed, got.overflowed);
                  errs++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_MATCH_GAIN:       match_gain       = csr_wdata[3:0];
               CSR_MISMATCH_PENALTY: mismatch_penalty = csr_wdata;
               CSR_GAP_PENALTY:      gap_penalty      = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.func)
               FUNC_APPEND_FIRST: begin
                  if (first_len < FIRST_CAP) begin
                     first_syms[first_len] = req_data.symbol;
                     first_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               FUNC_APPEND_SECOND: begin
                  if (second_len < SECOND_CAP) begin
                     second_syms[second_len] = req_data.symbol;
                     second_len++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               FUNC_RUN: begin
                  want.align_score = predict_score();
                  want.overflowed  = dropped;
                  score_q = {score_q, want};
                  first_len  = 0;
                  second_len = 0;
                  dropped    = 1'b0;
               end
               default: ;
            endcase
         end
      end
      mismatch_count <= errs;
      pending_count  <= score_q.size();
      scores_checked <= checked;
      overflow_seen  <= flagged;
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the global alignment scorer: directed corner
// words, a capacity pass that fills both strings past their ends, then
// random string pairs under several register settings with random idling,
// a long result hold-off and a drain pause. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_top;
   import gas_pkg::*;

   localparam func_type        FUNC_IGNORED     = func_type'(2'd3);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int              SETTLE_CYCLES    = 16;
   localparam int              HOLDOFF_CYCLES   = 400;
   localparam int              WATCHDOG_LIMIT   = 300000;
   localparam int              PHASE_WORDS      = 16;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int scores_checked;
   int overflow_seen;

   int words_sent       = 0;
   int settings_used    = 1;
   int quiet_cycles     = 0;
   bit idle_on          = 1'b0;
   int holdoff_requests = 0;
   int holdoffs_done    = 0;

   global_alignment_scorer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   alignment_score_checker score_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .scores_checked (scores_checked),
      .overflow_seen  (overflow_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Result receiver: random stall bursts, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (holdoffs_done < holdoff_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoffs_done++;
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input func_type f, input logic [SYM_W-1:0] s);
      req_type w;
      w.func   = f;
      w.symbol = s;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (f != FUNC_IGNORED) begin
         words_sent++;
      end
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Hold the input until every predicted score has come back, then settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_W-1:0] mg, input logic [CSR_W-1:0] mp,
                            input logic [CSR_W-1:0] gp);
      write_reg(CSR_MATCH_GAIN, mg);
      write_reg(CSR_MISMATCH_PENALTY, mp);
      write_reg(CSR_GAP_PENALTY, gp);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   // Load n and m symbols in random interleaving, then run
   task automatic send_pair(input int n, input int m, input bit narrow, input bit noisy);
      logic [SYM_W-1:0] pool [0:3];
      logic [SYM_W-1:0] s;
      int a, b, k;
      for (k = 0; k < 4; k++) begin
         pool[k] = SYM_W'($urandom_range(0, 255));
      end
      a = 0;
      b = 0;
      while (a < n || b < m) begin
         s = narrow ? pool[$urandom_range(0, 3)] : SYM_W'($urandom_range(0, 255));
         if (b >= m || (a < n && $urandom_range(0, 1) == 1)) begin
            send_word(FUNC_APPEND_FIRST, s);
            a++;
         end else begin
            send_word(FUNC_APPEND_SECOND, s);
            b++;
         end
         if (noisy && $urandom_range(0, 19) == 0) begin
            send_word(FUNC_IGNORED, SYM_W'($urandom_range(0, 255)));
         end
      end
      send_word(FUNC_RUN, SYM_W'($urandom_range(0, 255)));
   endtask

   task automatic random_phase(input int quota);
      int start, kind;
      start = words_sent;
      while (words_sent - start < quota) begin
         kind = $urandom_range(0, 19);
         case (kind)
            0: send_word(FUNC_RUN, SYM_W'($urandom_range(0, 255)));
            1: begin
               if ($urandom_range(0, 1) == 1) begin
                  send_pair($urandom_range(1, 8), 0, 1'b0, 1'b1);
               end else begin
                  send_pair(0, $urandom_range(1, 8), 1'b0, 1'b1);
               end
            end
            2: repeat ($urandom_range(1, 3))
                  send_word(FUNC_IGNORED, SYM_W'($urandom_range(0, 255)));
            3: send_pair($urandom_range(10, 40), $urandom_range(10, 40),
                         1'($urandom_range(0, 1)), 1'b1);
            default: send_pair($urandom_range(0, 10), $urandom_range(0, 10),
                               1'($urandom_range(0, 1)), 1'b1);
         endcase
      end
   endtask

   initial begin
      int phase;
      logic [CSR_W-1:0] mg, mp, gp;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Corner words under the reset costs
      send_word(FUNC_RUN, 8'h00);
      send_word(FUNC_APPEND_FIRST, 8'h00);
      send_word(FUNC_RUN, 8'hFF);
      send_word(FUNC_APPEND_SECOND, 8'hFF);
      send_word(FUNC_RUN, 8'h5A);
      send_word(FUNC_APPEND_FIRST, 8'h01);
      send_word(FUNC_APPEND_SECOND, 8'h01);
      send_word(FUNC_RUN, 8'h00);
      send_word(FUNC_APPEND_FIRST, 8'h00);
      send_word(FUNC_APPEND_SECOND, 8'hFF);
      send_word(FUNC_RUN, 8'hA5);
      send_word(FUNC_IGNORED, 8'hFF);
      send_word(FUNC_APPEND_FIRST, 8'h80);
      send_word(FUNC_IGNORED, 8'h7F);
      send_word(FUNC_APPEND_SECOND, 8'h80);
      send_word(FUNC_RUN, 8'h00);
      send_word(FUNC_APPEND_FIRST, 8'hAA);
      send_word(FUNC_APPEND_FIRST, 8'h55);
      send_word(FUNC_APPEND_SECOND, 8'h55);
      send_word(FUNC_APPEND_SECOND, 8'hAA);
      send_word(FUNC_RUN, 8'hFF);
      drain_results();

      // Fill both strings past capacity in one run, then run on empty strings
      idle_on = 1'b1;
      send_pair(257, 257, 1'b1, 1'b0);
      send_word(FUNC_RUN, 8'h00);
      drain_results();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(5'd15, 5'h11, 5'h11);
            1: configure(5'd0, 5'd0, 5'd0);
            2: begin
               write_reg(CSR_UNUSED_INDEX, CSR_W'($urandom_range(0, 31)));
               configure(CSR_W'($urandom_range(0, 31)), CSR_W'($urandom_range(0, 31)),
                         CSR_W'($urandom_range(0, 31)));
            end
            3: configure(5'h1F, 5'h0F, 5'h10);
            4: begin
               mg = CSR_W'($urandom_range(0, 15));
               mp = CSR_W'(-$urandom_range(0, 15));
               gp = CSR_W'(-$urandom_range(0, 15));
               configure(mg, mp, gp);
            end
            default: configure(5'd2, 5'h1F, 5'h1F);
         endcase
         idle_on = (phase != 5);
         if (phase == 2) begin
            // Stall the result side while short runs keep arriving
            holdoff_requests++;
            repeat (4) send_pair($urandom_range(0, 3), $urandom_range(0, 3), 1'b0, 1'b0);
         end
         if (phase == 3) begin
            random_phase(PHASE_WORDS / 2);
            drain_results();
         end
         random_phase(PHASE_WORDS);
         drain_results();
      end

      $display("Covered %0d words and %0d checked scores, %0d of them with dropped appends",
               words_sent, scores_checked, overflow_seen);
      $display("Register settings applied: %0d, from zero costs to raw out-of-range codes",
               settings_used);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
